FILE: rtl/gsmd_pkg.sv
package gsmd_pkg;

    // Field and register widths.
    localparam int SAMPLE_W    = 16;
    localparam int CORR_W      = 17;
    localparam int THRESH_W    = 15;
    localparam int COUNT_W     = 8;
    localparam int SUM_W       = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 15;

    // Serial divider: one quotient bit per step over the whole sum.
    localparam int DIV_STEPS   = SUM_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // Register reset values, in raw units (131 LSB per degree per second).
    localparam logic [THRESH_W-1:0] ENTER_THRESHOLD_RST = 15'd655;
    localparam logic [THRESH_W-1:0] EXIT_THRESHOLD_RST  = 15'd1048;
    localparam logic [COUNT_W-1:0]  CONFIRM_COUNT_RST   = 8'd12;
    localparam logic [COUNT_W-1:0]  LOST_COUNT_RST      = 8'd5;
    localparam logic [COUNT_W-1:0]  CALIB_SAMPLES_RST   = 8'd80;

    localparam logic [COUNT_W-1:0]  RUN_MAX             = '1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_ENTER_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EXIT_THRESHOLD  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CONFIRM_COUNT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LOST_COUNT      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CALIB_SAMPLES   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT,
        ST_DIV,
        ST_CLASS,
        ST_EMIT
    } t_state;

endpackage

FILE: rtl/gsmd_div.sv
module gsmd_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [gsmd_pkg::SUM_W-1:0]   i_dividend,
    input  logic [gsmd_pkg::COUNT_W-1:0]        i_divisor,
    output logic                                o_done,
    output logic signed [gsmd_pkg::SAMPLE_W-1:0] o_quotient
);
    import gsmd_pkg::*;

    // Restoring divider on magnitudes; the sign is put back at the end so the
    // quotient truncates toward zero.
    logic                   r_busy;
    logic                   r_done;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic [COUNT_W-1:0]     r_rem;
    logic [SUM_W-1:0]       r_quo;
    logic [COUNT_W-1:0]     r_div;
    logic                   r_neg;

    logic [COUNT_W:0]       w_shift;
    logic                   w_fits;
    logic [COUNT_W:0]       w_diff;
    logic [SUM_W-1:0]       w_mag;

    assign w_shift = {r_rem, r_quo[SUM_W-1]};
    assign w_fits  = (w_shift >= {1'b0, r_div});
    assign w_diff  = w_shift - {1'b0, r_div};
    assign w_mag   = i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= w_mag;
            r_div <= i_divisor;
            r_neg <= i_dividend[SUM_W-1];
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[COUNT_W-1:0] : w_shift[COUNT_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], w_fits};
        end
    end

    // The quotient magnitude never exceeds 32768, so its low bits carry it.
    assign o_done     = r_done;
    assign o_quotient = r_neg ? SAMPLE_W'(-r_quo[SAMPLE_W-1:0]) : r_quo[SAMPLE_W-1:0];

endmodule

FILE: rtl/gyro_straight_motion_detector_unit.sv
// Straight-motion detector for a raw yaw-rate stream at 131 LSB per degree
// per second. After reset the first calib_samples words are summed and give
// no result; when the last of them arrives the bias becomes the sum divided
// by the count, truncated toward zero. Every later word has the bias
// subtracted, and its magnitude is compared with an enter and an exit
// threshold: below enter counts as straight, above exit counts as curve, in
// between leaves both run counters alone. The straight flag is set after
// confirm_count straight words in a row and cleared after lost_count curve
// words; the clear wins. Each such word gives one result word carrying the
// flag and the corrected rate. Each word is handled by a small sequencer
// and the input is stalled until it is done. The last calibration word also
// waits for the bias from a bit-serial divider that retires one quotient bit
// per cycle over the 24-bit sum, and a tracking word passes the sort,
// classify and emit states, waiting while the previous result word still
// sits unclaimed in the output register.
module gyro_straight_motion_detector_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,

    // Configuration write port.
    input  logic                                   i_cfg_we,
    input  logic [gsmd_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [gsmd_pkg::CFG_DATA_W-1:0]        i_cfg_data,

    // Input channel.
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [gsmd_pkg::SAMPLE_W-1:0]   i_rate_sample,

    // Output channel.
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic                                   o_straight,
    output logic signed [gsmd_pkg::CORR_W-1:0]     o_corrected_rate
);
    import gsmd_pkg::*;

    // Configuration registers.
    logic [THRESH_W-1:0]        r_enter_threshold;
    logic [THRESH_W-1:0]        r_exit_threshold;
    logic [COUNT_W-1:0]         r_confirm_count;
    logic [COUNT_W-1:0]         r_lost_count;
    logic [COUNT_W-1:0]         r_calib_samples;

    // Sequencer and detector state.
    t_state                     r_state, n_state;
    logic signed [SAMPLE_W-1:0] r_sample, n_sample;
    logic signed [SUM_W-1:0]    r_calib_sum, n_calib_sum;
    logic [COUNT_W-1:0]         r_calib_seen, n_calib_seen;
    logic signed [SAMPLE_W-1:0] r_rate_bias, n_rate_bias;
    logic [COUNT_W-1:0]         r_straight_run, n_straight_run;
    logic [COUNT_W-1:0]         r_curve_run, n_curve_run;
    logic                       r_flag, n_flag;
    logic signed [CORR_W-1:0]   r_corr, n_corr;
    logic                       r_div_start, n_div_start;

    // Output register.
    logic                       r_out_valid, n_out_valid;
    logic                       r_out_straight, n_out_straight;
    logic signed [CORR_W-1:0]   r_out_corr, n_out_corr;

    logic                       w_div_done;
    logic signed [SAMPLE_W-1:0] w_quotient;
    logic [COUNT_W-1:0]         w_seen_inc;
    logic [CORR_W-1:0]          w_mag;
    logic                       w_flag;

    gsmd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_calib_sum),
        .i_divisor  (r_calib_seen),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enter_threshold <= ENTER_THRESHOLD_RST;
            r_exit_threshold  <= EXIT_THRESHOLD_RST;
            r_confirm_count   <= CONFIRM_COUNT_RST;
            r_lost_count      <= LOST_COUNT_RST;
            r_calib_samples   <= CALIB_SAMPLES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ENTER_THRESHOLD: r_enter_threshold <= i_cfg_data[THRESH_W-1:0];
                REG_EXIT_THRESHOLD:  r_exit_threshold  <= i_cfg_data[THRESH_W-1:0];
                REG_CONFIRM_COUNT:   r_confirm_count   <= i_cfg_data[COUNT_W-1:0];
                REG_LOST_COUNT:      r_lost_count      <= i_cfg_data[COUNT_W-1:0];
                REG_CALIB_SAMPLES:   r_calib_samples   <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_calib_sum    <= '0;
            r_calib_seen   <= '0;
            r_rate_bias    <= '0;
            r_straight_run <= '0;
            r_curve_run    <= '0;
            r_flag         <= 1'b0;
            r_div_start    <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_calib_sum    <= n_calib_sum;
            r_calib_seen   <= n_calib_seen;
            r_rate_bias    <= n_rate_bias;
            r_straight_run <= n_straight_run;
            r_curve_run    <= n_curve_run;
            r_flag         <= n_flag;
            r_div_start    <= n_div_start;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample       <= n_sample;
        r_corr         <= n_corr;
        r_out_straight <= n_out_straight;
        r_out_corr     <= n_out_corr;
    end

    assign w_seen_inc = r_calib_seen + 1'b1;
    assign w_mag      = r_corr[CORR_W-1] ? CORR_W'(-r_corr) : CORR_W'(r_corr);

    // Set first, then clear, so a clear wins when both tests hold.
    always_comb begin
        w_flag = r_flag;
        if (r_straight_run >= r_confirm_count) begin
            w_flag = 1'b1;
        end
        if (r_curve_run >= r_lost_count) begin
            w_flag = 1'b0;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_sample       = r_sample;
        n_calib_sum    = r_calib_sum;
        n_calib_seen   = r_calib_seen;
        n_rate_bias    = r_rate_bias;
        n_straight_run = r_straight_run;
        n_curve_run    = r_curve_run;
        n_flag         = r_flag;
        n_corr         = r_corr;
        n_div_start    = 1'b0;
        n_out_straight = r_out_straight;
        n_out_corr     = r_out_corr;

        // A waiting result word leaves when the consumer takes it.
        n_out_valid    = r_out_valid && i_out_stall;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_sample = i_rate_sample;
                    n_state  = ST_SORT;
                end
            end

            ST_SORT: begin
                if (r_calib_seen < r_calib_samples) begin
                    // Calibration word: accumulate, and start the bias
                    // division once the count is reached.
                    n_calib_sum  = r_calib_sum + SUM_W'(r_sample);
                    n_calib_seen = w_seen_inc;
                    if (w_seen_inc == r_calib_samples) begin
                        n_div_start = 1'b1;
                        n_state     = ST_DIV;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_corr  = CORR_W'(r_sample) - CORR_W'(r_rate_bias);
                    n_state = ST_CLASS;
                end
            end

            ST_DIV: begin
                if (w_div_done) begin
                    n_rate_bias = w_quotient;
                    n_state     = ST_IDLE;
                end
            end

            ST_CLASS: begin
                // The straight test goes first, so it wins when the
                // thresholds are crossed.
                if (w_mag < CORR_W'(r_enter_threshold)) begin
                    if (r_straight_run != RUN_MAX) begin
                        n_straight_run = r_straight_run + 1'b1;
                    end
                    n_curve_run = '0;
                end else if (w_mag > CORR_W'(r_exit_threshold)) begin
                    if (r_curve_run != RUN_MAX) begin
                        n_curve_run = r_curve_run + 1'b1;
                    end
                    n_straight_run = '0;
                end
                n_state = ST_EMIT;
            end

            ST_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_flag         = w_flag;
                    n_out_straight = w_flag;
                    n_out_corr     = r_corr;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall       = (r_state != ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_straight       = r_out_straight;
    assign o_corrected_rate = r_out_corr;

endmodule
